// ----- rtl/signed_rank_density_macros.svh -----
// ----------------------------------------------------------------------------
// signed_rank_density_macros.svh
// Assertion shorthands shared by the signed-rank density checks.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RANK_DENSITY_MACROS_SVH
`define SIGNED_RANK_DENSITY_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define SRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// srd_pkg
// Widths, status codes, register map and controller states of the
// signed-rank density unit.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int X_W    = 13;  // rank_sum, two's complement
  localparam int CNT_W  = 51;  // subset_count
  localparam int N_W    = 6;   // sample size / scale exponent
  localparam int ST_W   = 2;   // status
  localparam int SW     = 11;  // n(n+1)/2 for n < 64
  localparam int PA_W   = 2;
  localparam int DATA_W = 32;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO_N = 2'd1;
  localparam logic [ST_W-1:0] ST_BIG_N  = 2'd2;

  localparam logic [PA_W-1:0] ADDR_SAMPLE_SIZE = 2'd0;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_PASS   = 5'b00100,
    S_GAP    = 5'b01000,
    S_LOOKUP = 5'b10000
  } state_t;

endpackage

// ----- rtl/signed_rank_density.sv -----
// ----------------------------------------------------------------------------
// signed_rank_density
// Wilcoxon signed-rank density: subset counts of ranks 1..n from a table.
// ----------------------------------------------------------------------------
// Use: write n to sample_size over the APB port (byte address 0), then send
// rank_sum words on the in_ channel. Each word gives one out_ word: the
// number of subsets of 1..n summing to rank_sum, n as scale exponent
// (density = count * 2^-n) and a status code.
// Counts live in one synchronous RAM holding the lower half of the
// symmetric distribution (entries 0..u/2, u = n(n+1)/2).
// Latency: with the table built, a word accepted at one edge is shown on
// out_valid after the next edge, and a new word may be taken every cycle;
// the single read of the RAM per query sets that figure.
// Build: the first in-range query after reset or after n changes triggers
// a table build before it is answered: a clear of entries 0..h, then for
// each rank i = 1..min(n,h) one pass over entries h down to i plus one gap
// state, then one lookup (h = u/2). The RAM's two read ports and one write
// port set the one-entry-per-cycle pace. in_stall is high throughout.
// Reset leaves n = 1 and marks the table as not built. The RAM itself is
// not cleared. When the receiver stalls, the result word holds and
// at most one further query is taken before in_stall rises.
// ----------------------------------------------------------------------------
module signed_rank_density #(
  parameter int MAX_N = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [srd_pkg::X_W-1:0] in_rank_sum,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srd_pkg::CNT_W-1:0]     out_subset_count,
  output logic [srd_pkg::N_W-1:0]       out_scale_exponent,
  output logic [srd_pkg::ST_W-1:0]      out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srd_pkg::PA_W-1:0]      paddr,
  input  logic [srd_pkg::DATA_W-1:0]    pwdata,
  output logic [srd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import srd_pkg::*;

  localparam int DEPTH = ((MAX_N * (MAX_N + 1)) / 2) / 2 + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = MAX_N - 1;  // a count for n ranks stays below 2^n

  // configuration
  logic [N_W-1:0] sample_size_r;

  // controller
  state_t         state_r, state_nxt;
  logic           table_ready_r;
  logic [N_W-1:0] built_size_r;

  // query held across a build
  logic [N_W-1:0]  q_n_r;
  logic [ST_W-1:0] q_status_r;
  logic            q_zero_r;
  logic [SW-1:0]   q_idx_r;

  // build counters
  logic [SW-1:0]  bk_r;
  logic [N_W-1:0] bi_r;
  logic [SW-1:0]  b_half_r;
  logic           wb_v_r;
  logic [AW-1:0]  wb_addr_r;

  // result path
  logic             pend_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [N_W-1:0]   out_n_r;
  logic [ST_W-1:0]  out_st_r;

  // table RAM
  logic [TW-1:0] mem [DEPTH];
  logic [TW-1:0] rd_a_r, rd_b_r;
  logic          ra_en, rb_en, mem_we;
  logic [AW-1:0] ra_addr, rb_addr, wa_addr;
  logic [TW-1:0] wdata;

  // query decode
  logic [N_W-1:0]  qn;
  logic [ST_W-1:0] qst;
  logic [12:0]     prod;
  logic [SW-1:0]   u, half, x_lo, idx;
  logic            in_rng, need_build, out_free, in_acc, cfg_wr;
  logic [N_W-1:0]  bi_inc;

  assign qn   = sample_size_r;
  assign prod = 13'(qn) * (13'(qn) + 13'd1);
  assign u    = SW'(prod >> 1);
  assign half = u >> 1;
  assign x_lo = SW'(in_rank_sum[X_W-2:0]);
  assign in_rng = !in_rank_sum[X_W-1] && (in_rank_sum[X_W-2:0] <= (X_W-1)'(u));
  assign idx  = (x_lo > half) ? (u - x_lo) : x_lo;

  always_comb begin
    if (qn == '0) begin
      qst = ST_ZERO_N;
    end else if (qn >= N_W'(MAX_N)) begin
      qst = ST_BIG_N;
    end else begin
      qst = ST_OK;
    end
  end

  assign need_build = (qst == ST_OK) && in_rng && (!table_ready_r || built_size_r != qn);
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && (!pend_r || out_free));
  assign in_acc     = in_valid && !in_stall;
  assign bi_inc     = bi_r + N_W'(1);

  // RAM ports: port a serves queries and w[k], port b serves w[k-i]
  assign ra_en   = (state_r == S_PASS) || (state_r == S_LOOKUP) ||
                   (in_acc && !need_build && qst == ST_OK && in_rng);
  assign ra_addr = (state_r == S_PASS)   ? bk_r[AW-1:0] :
                   (state_r == S_LOOKUP) ? q_idx_r[AW-1:0] : idx[AW-1:0];
  assign rb_en   = (state_r == S_PASS);
  assign rb_addr = AW'(bk_r - SW'(bi_r));
  assign mem_we  = (state_r == S_CLEAR) || wb_v_r;
  assign wa_addr = (state_r == S_CLEAR) ? bk_r[AW-1:0] : wb_addr_r;
  assign wdata   = (state_r == S_CLEAR) ? ((bk_r == '0) ? TW'(1) : '0)
                                        : (rd_a_r + rd_b_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa_addr] <= wdata;
    end
    if (ra_en) begin
      rd_a_r <= mem[ra_addr];
    end
    if (rb_en) begin
      rd_b_r <= mem[rb_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && need_build) state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        if (bk_r == b_half_r) state_nxt = (b_half_r != '0) ? S_PASS : S_LOOKUP;
      end
      S_PASS: begin
        if (bk_r == SW'(bi_r)) state_nxt = S_GAP;
      end
      S_GAP: begin
        // gap lets the last write of a pass land before the next pass reads
        if (bi_inc <= q_n_r && SW'(bi_inc) <= b_half_r) begin
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      table_ready_r <= 1'b0;
      built_size_r  <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      wb_v_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wb_v_r  <= (state_r == S_PASS);

      if (out_free) out_valid_r <= pend_r;

      if ((in_acc && !need_build) || (state_r == S_LOOKUP)) begin
        pend_r <= 1'b1;
      end else if (out_free) begin
        pend_r <= 1'b0;
      end

      if (state_r == S_LOOKUP) begin
        table_ready_r <= 1'b1;
        built_size_r  <= q_n_r;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    wb_addr_r <= bk_r[AW-1:0];

    if (pend_r && out_free) begin
      out_cnt_r <= q_zero_r ? '0 : CNT_W'(rd_a_r);
      out_n_r   <= q_n_r;
      out_st_r  <= q_status_r;
    end

    if (in_acc) begin
      q_n_r      <= qn;
      q_status_r <= qst;
      q_zero_r   <= !((qst == ST_OK) && in_rng);
      q_idx_r    <= idx;
      b_half_r   <= half;
      bk_r       <= '0;
    end

    case (state_r)
      S_CLEAR: begin
        if (bk_r == b_half_r) begin
          bk_r <= b_half_r;
          bi_r <= N_W'(1);
        end else begin
          bk_r <= bk_r + SW'(1);
        end
      end
      S_PASS: bk_r <= bk_r - SW'(1);
      S_GAP: begin
        bk_r <= b_half_r;
        bi_r <= bi_inc;
      end
      default: ;
    endcase
  end

  // configuration port
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_size_r <= N_W'(1);
    end else if (cfg_wr && paddr == ADDR_SAMPLE_SIZE) begin
      sample_size_r <= pwdata[N_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_SAMPLE_SIZE) ? DATA_W'(sample_size_r) : '0;
  assign pready = 1'b1;

  assign out_valid          = out_valid_r;
  assign out_subset_count   = out_cnt_r;
  assign out_scale_exponent = out_n_r;
  assign out_status         = out_st_r;

endmodule

// ----- rtl/srd_checker.sv -----
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks on the result channel of the signed-rank density unit.
// ----------------------------------------------------------------------------
`include "signed_rank_density_macros.svh"

module srd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [srd_pkg::CNT_W-1:0] out_subset_count,
  input logic [srd_pkg::N_W-1:0]   out_scale_exponent,
  input logic [srd_pkg::ST_W-1:0]  out_status
);
  import srd_pkg::*;

  // an error word never carries a count
  `SRD_ASSERT_NOW(a_err_no_count, out_valid && out_status != ST_OK, out_subset_count == '0, "error word with nonzero count")

  // zero sample size and the domain error go together
  `SRD_ASSERT_NOW(a_zero_n_status, out_valid, (out_status == ST_ZERO_N) == (out_scale_exponent == '0), "zero n and status disagree")

  // status takes only its three codes
  `SRD_ASSERT_NOW(a_status_code, out_valid, out_status == ST_OK || out_status == ST_ZERO_N || out_status == ST_BIG_N, "undefined status code")

  // a stalled word stays put
  `SRD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_subset_count) && $stable(out_scale_exponent) && $stable(out_status), "stalled word changed")

endmodule

bind signed_rank_density srd_checker u_srd_checker (.*);

// ----- test/signed_rank_density_tb.sv -----
// ----------------------------------------------------------------------------
// signed_rank_density_tb
// Checks the signed-rank density unit against a subset-sum count computed
// locally. Sample sizes are set over APB, covering zero, the error range and
// sizes up to the table limit. Queries sweep the whole rank_sum range while
// both sides idle at random in most phases, plus one long output hold-off.
// ----------------------------------------------------------------------------
module signed_rank_density_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int SIZE_LIMIT  = 50;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 45;
  localparam logic [PA_W-1:0] ADDR_SPARE = 2'd2;  // nothing mapped here

  // expected results, one per accepted rank_sum word
  class density_board;
    typedef struct {
      logic [CNT_W-1:0] count;
      logic [N_W-1:0]   scale;
      logic [ST_W-1:0]  status;
    } density_t;

    density_t        awaited[$];
    longint unsigned ways[];
    int              ranks;
    int              total;
    int              queries;
    int              checked;
    int              mismatches;

    function new();
      queries    = 0;
      checked    = 0;
      mismatches = 0;
      set_size(1);
    endfunction

    // number of subsets of 1..n for every sum 0..n(n+1)/2, for n below SIZE_LIMIT
    function void set_size(int n);
      ranks = n;
      total = n * (n + 1) / 2;
      ways  = new[total + 1];
      foreach (ways[k]) ways[k] = 0;
      ways[0] = 1;
      if (n < SIZE_LIMIT) begin
        for (int i = 1; i <= n; i++)
          for (int k = total; k >= i; k--)
            ways[k] += ways[k - i];
      end
    endfunction

    function void note_query(logic signed [X_W-1:0] x);
      density_t e;
      int       xv;
      xv       = x;
      e.count  = '0;
      e.scale  = ranks[N_W-1:0];
      e.status = ST_OK;
      if (ranks == 0) e.status = ST_ZERO_N;
      else if (ranks >= SIZE_LIMIT) e.status = ST_BIG_N;
      else if (xv >= 0 && xv <= total) e.count = ways[xv][CNT_W-1:0];
      awaited.push_back(e);
      queries++;
    endfunction

    function void check_result(logic [CNT_W-1:0] cnt, logic [N_W-1:0] sc,
                               logic [ST_W-1:0] st);
      density_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing pending: subset_count %0d", cnt);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (cnt !== e.count) begin
        $error("subset_count: expected %0d, got %0d", e.count, cnt);
        mismatches++;
      end
      if (sc !== e.scale) begin
        $error("scale_exponent: expected %0d, got %0d", e.scale, sc);
        mismatches++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic signed [X_W-1:0]    in_rank_sum  = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [CNT_W-1:0]         out_subset_count;
  logic [N_W-1:0]           out_scale_exponent;
  logic [ST_W-1:0]          out_status;
  logic                     psel         = 1'b0;
  logic                     penable      = 1'b0;
  logic                     pwrite       = 1'b0;
  logic [PA_W-1:0]          paddr        = '0;
  logic [DATA_W-1:0]        pwdata       = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  density_board board = new();
  int send_idle_pct = 18;
  int recv_idle_pct = 83;
  int stall_burst   = 0;
  int sizes_set     = 0;

  signed_rank_density #(.MAX_N(SIZE_LIMIT)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rank_sum        (in_rank_sum),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_subset_count   (out_subset_count),
    .out_scale_exponent (out_scale_exponent),
    .out_status         (out_status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_subset_count, out_scale_exponent, out_status);
  end

  task automatic send_word(input int x);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_rank_sum <= X_W'(x);
    do @(posedge clk); while (in_stall);
    board.note_query(X_W'(x));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // APB write once every pending word is back
  task automatic write_register(input logic [PA_W-1:0] addr, input logic [DATA_W-1:0] data);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SAMPLE_SIZE) begin
      board.set_size(int'(data[N_W-1:0]));
      sizes_set++;
    end
  endtask

  function automatic int pick_size(int p);
    case (p)
      3:       return 0;
      5:       return SIZE_LIMIT - 1;
      7:       return $urandom_range(SIZE_LIMIT, 63);
      10:      return $urandom_range(25, SIZE_LIMIT - 2);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // mostly sums inside 0..u, the rest below, above or anywhere
  function automatic int pick_sum(int u);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, u);
    if (r < 80) return -int'($urandom_range(1, 4096));
    if (r < 90) return $urandom_range(u + 1, 4095);
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  initial begin
    int                n;
    int                items;
    logic [DATA_W-1:0] data;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size n = 1: u = 1
    send_word(0);
    send_word(1);
    send_word(2);
    send_word(-1);
    write_register(ADDR_SAMPLE_SIZE, 32'hFFFF_FFC0);  // upper bits masked, n = 0
    send_word(0);
    send_word(5);
    write_register(ADDR_SAMPLE_SIZE, 32'd63);
    send_word(0);
    send_word(4095);
    write_register(ADDR_SAMPLE_SIZE, SIZE_LIMIT);
    send_word(10);
    write_register(ADDR_SPARE, 32'd7);                // must not touch n
    send_word(1);
    write_register(ADDR_SAMPLE_SIZE, 32'hFFFF_FFF1);  // n = 49, largest table
    send_word(0);
    send_word(612);
    send_word(613);
    send_word(1225);
    send_word(1226);
    send_word(-4096);
    send_word(4095);
    send_word(-1);
    send_word(300);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 18;
      end
      if (p == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      n    = pick_size(p);
      data = $urandom;
      data[N_W-1:0] = n[N_W-1:0];
      write_register(ADDR_SAMPLE_SIZE, data);
      items = (n == SIZE_LIMIT - 1) ? 20 : PHASE_ITEMS;
      for (int k = 0; k < items; k++) begin
        send_word(pick_sum(n * (n + 1) / 2));
        // long output hold-off while words keep coming
        if (p == 2 * PHASES / 3 && k == 10) stall_burst = 300;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d rank_sum queries over %0d sample-size writes,",
             board.queries, sizes_set);
    $display("  n from 0 to 63 and sums across the full signed range; %0d results checked.",
             board.checked);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
